@@ sv/dual_wheel_pid_speed_control_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dual wheel PID speed control block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PID_SPEED_CONTROL_MACROS_SVH
`define DUAL_WHEEL_PID_SPEED_CONTROL_MACROS_SVH

// Same-cycle implication
`define DWPSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dwpsc: same-cycle check failed");

// Next-cycle implication
`define DWPSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dwpsc: next-cycle check failed");

`endif

@@ sv/dwpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dwpsc_pkg
// Constants, gain register indexes and types of the dual wheel PID block.
// ----------------------------------------------------------------------------
package dwpsc_pkg;

  localparam int INTEGRAL_LIMIT = 300;
  localparam int OUTPUT_LIMIT   = 700;

  localparam int GAIN_W  = 8;
  localparam int ERR_W   = 18;
  localparam int INTEG_W = 10;
  localparam int DRIVE_W = 11;
  localparam int IDX_W   = 3;

  // gain register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_LEFT_PROP   = 3'd0,
    REG_LEFT_INTEG  = 3'd1,
    REG_LEFT_DERIV  = 3'd2,
    REG_RIGHT_PROP  = 3'd3,
    REG_RIGHT_INTEG = 3'd4,
    REG_RIGHT_DERIV = 3'd5
  } reg_idx_e;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd80;  // 5.0
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 8'd32;  // 2.0
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 8'd0;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic signed [INTEG_W-1:0] integral;
    logic signed [ERR_W-1:0]   prev_err;
  } wheel_state_t;

endpackage

@@ sv/dual_wheel_pid_speed_control.sv @@
// ----------------------------------------------------------------------------
// dual_wheel_pid_speed_control
// Two-wheel PID speed loop with clamped integral and saturated drive.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: targets + measured counts,
//                                               tuser: mode (1 = reverse)
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: left/right drive
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i (gains)
//
// From accept to result: input register, then the PID math feeds the
// result register. One item per cycle sustained while the output is not
// stalled; the integral/previous-error loop is closed in the compute stage.
// Async active-low reset clears valids, integrals, previous errors and
// loads the default gains. A stalled output holds the pipe; an empty input
// register still fills while the result waits. cfg_ready_o is always high.
//
module dual_wheel_pid_speed_control (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] left_target, [15:8] right_target,
  // [31:16] left_measured, [47:32] right_measured
  input  logic [47:0] s_axis_tdata,
  // [0] mode
  input  logic        s_axis_tuser,
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [10:0] left_drive, [21:11] right_drive, [23:22] zero
  output logic [23:0] m_axis_tdata,
  // gain register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int ERR_W   = dwpsc_pkg::ERR_W;
  localparam int INTEG_W = dwpsc_pkg::INTEG_W;
  localparam int DRIVE_W = dwpsc_pkg::DRIVE_W;

  // add error into integral, clamp to +/- limit
  function automatic logic signed [INTEG_W-1:0] clamp_integ(
    input logic signed [INTEG_W-1:0] integ,
    input logic signed [ERR_W-1:0]   err
  );
    logic signed [ERR_W:0] acc;
    logic signed [ERR_W:0] lim;
    acc = (ERR_W+1)'(integ) + (ERR_W+1)'(err);
    lim = (ERR_W+1)'(dwpsc_pkg::INTEGRAL_LIMIT);
    if (acc > lim)       clamp_integ = INTEG_W'(lim);
    else if (acc < -lim) clamp_integ = INTEG_W'(-lim);
    else                 clamp_integ = INTEG_W'(acc);
  endfunction

  // PID sum with Q4.4 gains (4 fraction bits), saturate, truncate toward zero
  function automatic logic signed [DRIVE_W-1:0] pid_drive(
    input logic signed [ERR_W-1:0]   err,
    input logic signed [INTEG_W-1:0] acc,
    input logic signed [ERR_W-1:0]   prev,
    input dwpsc_pkg::gains_t         g
  );
    logic signed [ERR_W+8:0]   p_term;
    logic signed [INTEG_W+8:0] i_term;
    logic signed [ERR_W:0]     diff;
    logic signed [ERR_W+9:0]   d_term;
    logic signed [31:0]        sum;
    logic signed [31:0]        lim;
    logic signed [31:0]        quo;
    p_term = err * $signed({1'b0, g.kp});
    i_term = acc * $signed({1'b0, g.ki});
    diff   = (ERR_W+1)'(err) - (ERR_W+1)'(prev);
    d_term = diff * $signed({1'b0, g.kd});
    sum    = 32'(p_term) + 32'(i_term) + 32'(d_term);
    lim    = 32'(dwpsc_pkg::OUTPUT_LIMIT * 16);
    quo    = (sum < 0) ? ((sum + 32'sd15) >>> 4) : (sum >>> 4);
    if (sum > lim)       pid_drive = DRIVE_W'(dwpsc_pkg::OUTPUT_LIMIT);
    else if (sum < -lim) pid_drive = DRIVE_W'(-dwpsc_pkg::OUTPUT_LIMIT);
    else                 pid_drive = DRIVE_W'(quo);
  endfunction

  // ---------------- gain registers ----------------
  dwpsc_pkg::gains_t left_gains_q, right_gains_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_gains_q  <= '{dwpsc_pkg::PROP_GAIN_RST, dwpsc_pkg::INTEG_GAIN_RST,
                         dwpsc_pkg::DERIV_GAIN_RST};
      right_gains_q <= '{dwpsc_pkg::PROP_GAIN_RST, dwpsc_pkg::INTEG_GAIN_RST,
                         dwpsc_pkg::DERIV_GAIN_RST};
    end else if (cfg_valid_i) begin
      unique case (dwpsc_pkg::reg_idx_e'(cfg_index_i))
        dwpsc_pkg::REG_LEFT_PROP:   left_gains_q.kp  <= cfg_data_i;
        dwpsc_pkg::REG_LEFT_INTEG:  left_gains_q.ki  <= cfg_data_i;
        dwpsc_pkg::REG_LEFT_DERIV:  left_gains_q.kd  <= cfg_data_i;
        dwpsc_pkg::REG_RIGHT_PROP:  right_gains_q.kp <= cfg_data_i;
        dwpsc_pkg::REG_RIGHT_INTEG: right_gains_q.ki <= cfg_data_i;
        dwpsc_pkg::REG_RIGHT_DERIV: right_gains_q.kd <= cfg_data_i;
        default: ;  // unused indexes: write dropped
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic in_vld_q, out_vld_q;
  logic advance;

  assign advance       = !out_vld_q || m_axis_tready;   // result slot free next edge
  assign s_axis_tready = !in_vld_q || advance;
  assign m_axis_tvalid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (advance)       out_vld_q <= in_vld_q;
    end
  end

  // ---------------- input register ----------------
  logic [47:0] in_data_q;
  logic        in_mode_q;

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_mode_q <= s_axis_tuser;
    end
  end

  // ---------------- PID math ----------------
  logic signed [ERR_W-1:0]   left_tgt, right_tgt, left_meas, right_meas;
  logic signed [ERR_W-1:0]   left_err, right_err;
  dwpsc_pkg::wheel_state_t   left_st_q, right_st_q, left_st_d, right_st_d;
  logic signed [DRIVE_W-1:0] left_drv, right_drv, right_drv_raw;

  always_comb begin
    left_tgt   = ERR_W'($signed({1'b0, in_data_q[7:0]}));
    right_tgt  = ERR_W'($signed({1'b0, in_data_q[15:8]}));
    left_meas  = ERR_W'($signed(in_data_q[31:16]));
    right_meas = ERR_W'($signed(in_data_q[47:32]));

    left_err  = left_tgt - left_meas;
    // reverse: the right encoder counts the other way
    right_err = in_mode_q ? (right_tgt + right_meas) : (right_tgt - right_meas);

    left_st_d.integral  = clamp_integ(left_st_q.integral, left_err);
    right_st_d.integral = clamp_integ(right_st_q.integral, right_err);
    left_st_d.prev_err  = left_err;
    right_st_d.prev_err = right_err;

    left_drv      = pid_drive(left_err, left_st_d.integral, left_st_q.prev_err,
                              left_gains_q);
    right_drv_raw = pid_drive(right_err, right_st_d.integral, right_st_q.prev_err,
                              right_gains_q);
    // forward: right motor is mounted mirrored
    right_drv     = in_mode_q ? right_drv_raw : -right_drv_raw;
  end

  // loop state moves only when the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_st_q  <= '0;
      right_st_q <= '0;
    end else if (in_vld_q && advance) begin
      left_st_q  <= left_st_d;
      right_st_q <= right_st_d;
    end
  end

  // ---------------- result register ----------------
  logic [DRIVE_W-1:0] left_out_q, right_out_q;

  always_ff @(posedge clk_i) begin
    if (in_vld_q && advance) begin
      left_out_q  <= left_drv;
      right_out_q <= right_drv;
    end
  end

  assign m_axis_tdata = {2'b00, right_out_q, left_out_q};

endmodule

@@ sv/dwpsc_checker.sv @@
// ----------------------------------------------------------------------------
// dwpsc_checker
// Port-level checks for the dual wheel PID speed control block.
// ----------------------------------------------------------------------------
`include "dual_wheel_pid_speed_control_macros.svh"

module dwpsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic signed [10:0] left_drv, right_drv;
  assign left_drv  = $signed(m_axis_tdata[10:0]);
  assign right_drv = $signed(m_axis_tdata[21:11]);

  // a pending result is not withdrawn
  `DWPSC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // input backs up only behind a stalled result
  `DWPSC_ASSERT_IMP(a_ready_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // drives stay within the saturation limits, pad bits [23:22] stay zero
  `DWPSC_ASSERT_IMP(a_left_range, m_axis_tvalid,
                    left_drv <= 11'sd700 && left_drv >= -11'sd700)
  `DWPSC_ASSERT_IMP(a_right_range, m_axis_tvalid,
                    right_drv <= 11'sd700 && right_drv >= -11'sd700 &&
                    m_axis_tdata[23:22] == 2'b00)

endmodule

bind dual_wheel_pid_speed_control dwpsc_checker u_dwpsc_checker (.*);
